// ----- src/psr_pkg.sv -----
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types, register indexes, palette endpoint table and shade blend
// helpers for the palette shade recolor unit.
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int PAL_ENTRIES = 18;

    typedef struct packed {
        logic [7:0] mask_code;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       end_of_image;
    } psr_pixel_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       painted;
        logic       last_out;
        logic       config_error;
    } psr_result_t;

    typedef struct packed {
        logic [4:0] pr;
        logic [4:0] pg;
        logic [4:0] pb;
        logic [4:0] sr;
        logic [4:0] sg;
        logic [4:0] sb;
    } psr_ends_t;

    localparam int ENDS_W = $bits(psr_ends_t);

    typedef logic [2:0] psr_cfg_idx_t;
    localparam psr_cfg_idx_t CFG_FIRST_COLOR  = 3'd0;
    localparam psr_cfg_idx_t CFG_SECOND_COLOR = 3'd1;
    localparam psr_cfg_idx_t CFG_NONE_CODE    = 3'd2;
    localparam psr_cfg_idx_t CFG_FIRST_BASE   = 3'd3;
    localparam psr_cfg_idx_t CFG_SECOND_BASE  = 3'd4;
    localparam psr_cfg_idx_t CFG_LAST_CODE    = 3'd5;

    typedef logic [2:0] psr_shade_t;
    localparam psr_shade_t SHADE_PRIMARY   = 3'd0;
    localparam psr_shade_t SHADE_QUARTER   = 3'd1;
    localparam psr_shade_t SHADE_THIRD     = 3'd2;
    localparam psr_shade_t SHADE_HALF      = 3'd3;
    localparam psr_shade_t SHADE_TWO_THIRD = 3'd4;
    localparam psr_shade_t SHADE_THREE_QTR = 3'd5;
    localparam psr_shade_t SHADE_SECONDARY = 3'd6;

    function automatic psr_ends_t palette_ends(input logic [4:0] idx);
        psr_ends_t e;
        case (idx)
            5'd0:    e = '{5'd19, 5'd19, 5'd15, 5'd9,  5'd9,  5'd6};
            5'd1:    e = '{5'd0,  5'd4,  5'd8,  5'd0,  5'd2,  5'd4};
            5'd2:    e = '{5'd20, 5'd16, 5'd2,  5'd12, 5'd9,  5'd2};
            5'd3:    e = '{5'd18, 5'd18, 5'd18, 5'd8,  5'd8,  5'd8};
            5'd4:    e = '{5'd19, 5'd10, 5'd4,  5'd11, 5'd6,  5'd2};
            5'd5:    e = '{5'd6,  5'd7,  5'd8,  5'd2,  5'd3,  5'd4};
            5'd6:    e = '{5'd2,  5'd14, 5'd5,  5'd0,  5'd8,  5'd2};
            5'd7:    e = '{5'd16, 5'd6,  5'd4,  5'd8,  5'd3,  5'd1};
            5'd8:    e = '{5'd8,  5'd10, 5'd16, 5'd4,  5'd5,  5'd8};
            5'd9:    e = '{5'd17, 5'd4,  5'd4,  5'd4,  5'd3,  5'd3};
            5'd10:   e = '{5'd4,  5'd6,  5'd11, 5'd1,  5'd2,  5'd5};
            5'd11:   e = '{5'd20, 5'd7,  5'd7,  5'd10, 5'd4,  5'd4};
            5'd12:   e = '{5'd3,  5'd3,  5'd3,  5'd1,  5'd1,  5'd1};
            5'd13:   e = '{5'd17, 5'd9,  5'd15, 5'd7,  5'd3,  5'd6};
            5'd14:   e = '{5'd5,  5'd6,  5'd4,  5'd1,  5'd2,  5'd0};
            5'd15:   e = '{5'd19, 5'd17, 5'd9,  5'd10, 5'd8,  5'd2};
            5'd16:   e = '{5'd12, 5'd16, 5'd18, 5'd3,  5'd6,  5'd8};
            5'd17:   e = '{5'd11, 5'd13, 5'd9,  5'd4,  5'd5,  5'd3};
            default: e = '0;
        endcase
        return e;
    endfunction

    // floor(x / 3) for x below 96
    function automatic logic [4:0] div3(input logic [6:0] x);
        logic [12:0] prod;
        prod = 13'(x) * 13'd43;
        return prod[11:7];
    endfunction

    function automatic logic [4:0] blend(input logic [4:0] p, input logic [4:0] s,
                                         input psr_shade_t shade);
        logic [4:0] ph;
        logic [4:0] sh;
        logic [4:0] mid;
        logic [4:0] r;
        ph  = p >> 1;
        sh  = s >> 1;
        mid = ph + sh;
        case (shade)
            SHADE_PRIMARY:   r = p;
            SHADE_QUARTER:   r = ph + (mid >> 1);
            SHADE_THIRD:     r = div3({1'b0, p, 1'b0} + 7'(s));
            SHADE_HALF:      r = mid;
            SHADE_TWO_THIRD: r = div3(7'(p) + {1'b0, s, 1'b0});
            SHADE_THREE_QTR: r = (mid >> 1) + sh;
            default:         r = s;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] widen(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

// ----- src/psr_ram.sv -----
// ----------------------------------------------------------------------------
// psr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module psr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/palette_shade_recolor_unit.sv -----
// ----------------------------------------------------------------------------
// palette_shade_recolor_unit
// Pixel recolor: mask code selects a palette colour and shade, channels are
// blended from RAM-held endpoints and widened from 5 to 8 bits.
// Result strobe: an accepted item passes the s1 registers, then the result register.
// Throughput: one item per cycle while busy is low; the receiver cannot stall.
// Reset: control and config registers take their reset values, then the endpoint
// RAM is loaded one entry per cycle, all PALETTE_SIZE entries, with busy high.
// ----------------------------------------------------------------------------
module palette_shade_recolor_unit
    import psr_pkg::*;
#(
    parameter int PALETTE_SIZE = 18
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  psr_pixel_t   pixel,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  psr_cfg_idx_t cfg_index,
    input  logic [7:0]   cfg_data,
    output logic         result_valid,
    output psr_result_t  result
);

    localparam int IDX_W = PALETTE_SIZE > 1 ? $clog2(PALETTE_SIZE) : 1;

    logic [4:0] first_color_reg;
    logic [4:0] second_color_reg;
    logic [7:0] none_code_reg;
    logic [7:0] first_base_reg;
    logic [7:0] second_base_reg;
    logic [7:0] last_code_reg;

    logic             fill_active_reg;
    logic [IDX_W-1:0] fill_idx_reg;

    logic        s1_valid_reg;
    logic        s1_paint_reg;
    logic        s1_err_reg;
    psr_shade_t  s1_shade_reg;
    psr_pixel_t  s1_pixel_reg;

    logic        result_valid_reg;
    psr_result_t result_reg;
    psr_result_t result_next;

    logic        accept;
    logic        err;
    logic        use_second;
    logic [4:0]  idx;
    logic [7:0]  shade_raw;
    psr_shade_t  shade;
    logic        paint;
    psr_ends_t   ends;
    logic [ENDS_W-1:0] rdata;

    assign busy      = fill_active_reg;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_color_reg  <= '0;
            second_color_reg <= '0;
            none_code_reg    <= 8'd0;
            first_base_reg   <= 8'd1;
            second_base_reg  <= 8'd8;
            last_code_reg    <= 8'd14;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FIRST_COLOR:  first_color_reg  <= cfg_data[4:0];
                CFG_SECOND_COLOR: second_color_reg <= cfg_data[4:0];
                CFG_NONE_CODE:    none_code_reg    <= cfg_data;
                CFG_FIRST_BASE:   first_base_reg   <= cfg_data;
                CFG_SECOND_BASE:  second_base_reg  <= cfg_data;
                CFG_LAST_CODE:    last_code_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // load endpoint table after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_active_reg <= 1'b1;
            fill_idx_reg    <= '0;
        end
        else if (fill_active_reg)
        begin
            if (fill_idx_reg == IDX_W'(PALETTE_SIZE - 1))
            begin
                fill_active_reg <= 1'b0;
            end
            else
            begin
                fill_idx_reg <= fill_idx_reg + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        err = ({1'b0, first_color_reg} >= 6'(PALETTE_SIZE))
           || ({1'b0, second_color_reg} >= 6'(PALETTE_SIZE));
        use_second = pixel.mask_code >= second_base_reg;
        idx        = use_second ? second_color_reg : first_color_reg;
        shade_raw  = pixel.mask_code - (use_second ? second_base_reg : first_base_reg);
        shade      = (shade_raw >= 8'(SHADE_SECONDARY)) ? SHADE_SECONDARY : shade_raw[2:0];
        paint      = !err && (pixel.mask_code != none_code_reg)
                  && (pixel.mask_code <= last_code_reg);
    end

    psr_ram #(
        .WIDTH(ENDS_W),
        .DEPTH(PALETTE_SIZE)
    ) u_ends_ram (
        .clk  (clk),
        .we   (fill_active_reg),
        .waddr(fill_idx_reg),
        .wdata(palette_ends(5'(fill_idx_reg))),
        .raddr(idx[IDX_W-1:0]),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_paint_reg <= paint;
            s1_err_reg   <= err;
            s1_shade_reg <= shade;
            s1_pixel_reg <= pixel;
        end
    end

    always_comb
    begin
        ends = psr_ends_t'(rdata);
        result_next.painted      = s1_paint_reg;
        result_next.last_out     = s1_pixel_reg.end_of_image;
        result_next.config_error = s1_err_reg;
        if (s1_paint_reg)
        begin
            result_next.out_red   = widen(blend(ends.pr, ends.sr, s1_shade_reg));
            result_next.out_green = widen(blend(ends.pg, ends.sg, s1_shade_reg));
            result_next.out_blue  = widen(blend(ends.pb, ends.sb, s1_shade_reg));
        end
        else
        begin
            result_next.out_red   = s1_pixel_reg.in_red;
            result_next.out_green = s1_pixel_reg.in_green;
            result_next.out_blue  = s1_pixel_reg.in_blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- src/psr_checker.sv -----
// ----------------------------------------------------------------------------
// psr_checker
// Port-level checks for the palette shade recolor unit, bound to the top.
// ----------------------------------------------------------------------------
module psr_checker
    import psr_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input psr_pixel_t   pixel,
    input logic         result_valid,
    input psr_result_t  result
);

    // every accepted item yields a result strobe
    a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 result_valid)
        else $error("accepted item produced no result");

    a_no_stray_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 2))
        else $error("result without accepted item");

    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.painted) |->
            (result.out_red == $past(pixel.in_red, 2))
            && (result.out_green == $past(pixel.in_green, 2))
            && (result.out_blue == $past(pixel.in_blue, 2)))
        else $error("unpainted item changed its colour");

    a_error_blocks_paint: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.config_error) |-> !result.painted)
        else $error("painted while palette index out of range");

    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last_out == $past(pixel.end_of_image, 2)))
        else $error("end of image flag lost");

endmodule

bind palette_shade_recolor_unit psr_checker u_psr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .pixel       (pixel),
    .result_valid(result_valid),
    .result      (result)
);
